/* sv/odometry_motion_decomposition_macros.svh */
// Assertion helpers for the odometry motion block.
`ifndef ODOMETRY_MOTION_DECOMPOSITION_MACROS_SVH
`define ODOMETRY_MOTION_DECOMPOSITION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/omd_pkg.sv */
package omd_pkg;

  localparam int CordicW = 37;

  localparam logic [1:0] CFG_TRANS_THR = 2'd0;
  localparam logic [1:0] CFG_ROT_THR   = 2'd1;

  localparam logic [30:0] TransThrRst = 31'd6554;
  localparam logic [14:0] RotThrRst   = 15'd1043;
  localparam logic [30:0] ShortTrans  = 31'd655;
  localparam logic [16:0] QuarterTurn = 17'd16384;
  localparam logic [15:0] HalfTurn    = 16'h8000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ODO_START,
    S_ODO_WAIT,
    S_SCAN_SQ,
    S_SCAN_RUN,
    S_SCAN_FIN
  } omd_state_t;

  // atan(2^-i), 2^32 per full turn
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/odometry_motion_decomposition.sv */
// Odometry motion decomposition (rotation, translation, rotation).
// in_*  : one beat per odometry sample (in_tuser=0) or scan event (in_tuser=1).
//         Odometry beats update the pose accumulators and never produce output;
//         the first one only seeds the previous pose. A scan beat before any
//         odometry is swallowed.
// out_* : one beat per seeded scan event with translation, two rotations,
//         the reverse flag and motion_ready.
// cfg_* : write-only threshold registers; the user must write them only while
//         the block is idle, which the block itself does not enforce.
// Operation: an odometry beat holds the block for four 16x16 products, then the
//   shared CORDIC unit, one angle bit per cycle. A scan beat: two 32x32
//   squares, then a bit-serial square root while the CORDIC unit finds the
//   heading in parallel; the result then waits in S_SCAN_FIN for the output
//   register to free. The block takes no new beat until it is idle again.
// Reset (rst_n low, synchronous) clears the pose state, the accumulators and
//   loads the default thresholds.
// A stalled receiver holds the result in the output register; the next input
//   beat is still taken and worked on, and only a finished scan result waits
//   for the output register to free.
`include "odometry_motion_decomposition_macros.svh"

module odometry_motion_decomposition
  import omd_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[31:0], pos_y[63:32], quat_w[79:64], quat_x[95:80],
  // quat_y[111:96], quat_z[127:112]
  input  logic [127:0] in_tdata,
  // command[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // motion_ready[0], trans_len[31:1], rot_first[47:32],
  // rot_second[63:48], reverse[64], zero pad[71:65]
  output logic [71:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  omd_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic [30:0] trans_thr_r;
  logic [14:0] rot_thr_r;

  logic               seeded_r;
  logic signed [31:0] last_x_r, last_y_r, sum_dx_r, sum_dy_r;
  logic [15:0]        last_yaw_r, seg_yaw_r, sum_dyaw_r;

  logic signed [31:0] cx_r, cy_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [32:0] acc_s_r;
  logic [31:0]        acc_c_r;
  logic [63:0]        sq_acc_r;

  logic        out_valid_r;
  logic [71:0] out_data_r;

  logic in_acc, scan_go;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign scan_go   = in_acc && in_tuser && seeded_r;

  // pose products, one per cycle
  logic signed [15:0] ma, mb;
  logic signed [31:0] mprod;
  always_comb begin
    unique case (cnt_r)
      2'd0:    begin ma = qw_r; mb = qz_r; end
      2'd1:    begin ma = qx_r; mb = qy_r; end
      2'd2:    begin ma = qy_r; mb = qy_r; end
      default: begin ma = qz_r; mb = qz_r; end
    endcase
  end
  assign mprod = ma * mb;

  logic signed [33:0] sn, cs;
  assign sn = {acc_s_r, 1'b0};
  assign cs = $signed(34'h0_4000_0000) - $signed({1'b0, acc_c_r, 1'b0});

  // magnitude squares
  logic [31:0] dx_abs, dy_abs, sq_op;
  logic [63:0] sq_prod, sq_sum;
  assign dx_abs  = sum_dx_r[31] ? 32'(-sum_dx_r) : sum_dx_r;
  assign dy_abs  = sum_dy_r[31] ? 32'(-sum_dy_r) : sum_dy_r;
  assign sq_op   = cnt_r[0] ? dy_abs : dx_abs;
  assign sq_prod = {32'd0, sq_op} * {32'd0, sq_op};
  assign sq_sum  = sq_acc_r + sq_prod;

  // shared angle unit
  logic                      cor_start, cor_busy;
  logic signed [CordicW-1:0] cor_x, cor_y;
  logic [15:0]               cor_ang;
  always_comb begin
    if (state_r == S_ODO_START) begin
      cor_x = {{(CordicW-34){cs[33]}}, cs};
      cor_y = {{(CordicW-34){sn[33]}}, sn};
    end else begin
      cor_x = {{(CordicW-32){sum_dx_r[31]}}, sum_dx_r};
      cor_y = {{(CordicW-32){sum_dy_r[31]}}, sum_dy_r};
    end
  end
  assign cor_start = (state_r == S_ODO_START) || scan_go;

  omd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .busy  (cor_busy),
    .angle (cor_ang)
  );

  logic        sq_start, sq_busy;
  logic [31:0] sq_root;
  assign sq_start = (state_r == S_SCAN_SQ) && (cnt_r == 2'd1);

  omd_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_sum),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // odometry accumulate
  logic signed [33:0] nx, ny;
  logic signed [31:0] nx_sat, ny_sat;
  assign nx = 34'(sum_dx_r) + 34'(cx_r) - 34'(last_x_r);
  assign ny = 34'(sum_dy_r) + 34'(cy_r) - 34'(last_y_r);
  always_comb begin
    if (nx > 34'sh0_7FFF_FFFF)       nx_sat = 32'sh7FFF_FFFF;
    else if (nx < -34'sh0_8000_0000) nx_sat = 32'sh8000_0000;
    else                             nx_sat = nx[31:0];
    if (ny > 34'sh0_7FFF_FFFF)       ny_sat = 32'sh7FFF_FFFF;
    else if (ny < -34'sh0_8000_0000) ny_sat = 32'sh8000_0000;
    else                             ny_sat = ny[31:0];
  end

  // scan decomposition
  logic [30:0] tr;
  logic [15:0] rot1a, rot1, rot2;
  logic [16:0] r1_mag, yaw_mag;
  logic        rev, ready;
  always_comb begin
    tr      = sq_root[31] ? 31'h7FFF_FFFF : sq_root[30:0];
    rot1a   = (tr >= ShortTrans) ? (cor_ang - seg_yaw_r) : 16'd0;
    r1_mag  = rot1a[15] ? (17'h1_0000 - {1'b0, rot1a}) : {1'b0, rot1a};
    rev     = (tr > ShortTrans) && (r1_mag > QuarterTurn);
    rot1    = rev ? (rot1a + HalfTurn) : rot1a;
    rot2    = sum_dyaw_r - rot1;
    yaw_mag = sum_dyaw_r[15] ? (17'h1_0000 - {1'b0, sum_dyaw_r}) : {1'b0, sum_dyaw_r};
    ready   = (tr > trans_thr_r) || (yaw_mag > {2'b0, rot_thr_r});
  end

  logic out_free, fin_go;
  assign out_free = !out_valid_r || out_tready;
  assign fin_go   = (state_r == S_SCAN_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = 2'd0;
        if (in_acc) begin
          if (!in_tuser)    state_nxt = S_MUL;
          else if (seeded_r) state_nxt = S_SCAN_SQ;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = S_ODO_START;
      end
      S_ODO_START: state_nxt = S_ODO_WAIT;
      S_ODO_WAIT:  if (!cor_busy) state_nxt = S_IDLE;
      S_SCAN_SQ: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd1) state_nxt = S_SCAN_RUN;
      end
      S_SCAN_RUN: if (!cor_busy && !sq_busy) state_nxt = S_SCAN_FIN;
      S_SCAN_FIN: if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_thr_r <= TransThrRst;
      rot_thr_r   <= RotThrRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANS_THR: trans_thr_r <= cfg_wdata;
        CFG_ROT_THR:   rot_thr_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // input capture and product accumulators
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r <= in_tdata[31:0];
      cy_r <= in_tdata[63:32];
      qw_r <= in_tdata[79:64];
      qx_r <= in_tdata[95:80];
      qy_r <= in_tdata[111:96];
      qz_r <= in_tdata[127:112];
    end
    if (state_r == S_MUL) begin
      unique case (cnt_r)
        2'd0:    acc_s_r <= 33'(mprod);
        2'd1:    acc_s_r <= acc_s_r + 33'(mprod);
        2'd2:    acc_c_r <= $unsigned(mprod);
        default: acc_c_r <= acc_c_r + $unsigned(mprod);
      endcase
    end
    if (state_r == S_SCAN_SQ && cnt_r == 2'd0) sq_acc_r <= sq_prod;
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r   <= 1'b0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      last_yaw_r <= '0;
      seg_yaw_r  <= '0;
      sum_dx_r   <= '0;
      sum_dy_r   <= '0;
      sum_dyaw_r <= '0;
    end else if (state_r == S_ODO_WAIT && !cor_busy) begin
      last_x_r   <= cx_r;
      last_y_r   <= cy_r;
      last_yaw_r <= cor_ang;
      if (!seeded_r) begin
        seeded_r  <= 1'b1;
        seg_yaw_r <= cor_ang;
      end else begin
        sum_dx_r   <= nx_sat;
        sum_dy_r   <= ny_sat;
        sum_dyaw_r <= sum_dyaw_r + (cor_ang - last_yaw_r);
      end
    end else if (fin_go && ready) begin
      seg_yaw_r  <= last_yaw_r;
      sum_dx_r   <= '0;
      sum_dy_r   <= '0;
      sum_dyaw_r <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_data_r <= {7'd0, rev, rot2, rot1, tr, ready};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `OMD_ASSERT_NOW(a_idle_units, in_tready, !cor_busy && !sq_busy,
    "input taken while a unit is busy")
  `OMD_ASSERT_NOW(a_fin_done, state_r == S_SCAN_FIN, !cor_busy && !sq_busy,
    "scan result formed before units finished")
  `OMD_ASSERT_NEXT(a_odo_mul, in_acc && !in_tuser, state_r == S_MUL,
    "odometry beat did not start products")
  `OMD_ASSERT_NOW(a_seed_hold, 1'b1, !$fell(seeded_r),
    "seeded flag dropped outside reset")

endmodule

/* sv/omd_cordic.sv */
module omd_cordic
  import omd_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [CordicW-1:0] y_in,
  input  logic signed [CordicW-1:0] x_in,
  output logic                      busy,
  output logic [15:0]               angle
);

  localparam int CW = $clog2(STEPS);

  logic                      busy_r;
  logic                      zero_r;
  logic [CW-1:0]             cnt_r;
  logic signed [CordicW-1:0] x_r, y_r;
  logic [31:0]               ang_r;
  logic signed [CordicW-1:0] xs, ys;
  logic [31:0]               tab;
  logic [31:0]               rnd;

  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign tab = atan_tab(5'(cnt_r));
  assign rnd = ang_r + 32'h8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(STEPS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r   <= y_in;
          y_r   <= -x_in;
          ang_r <= 32'h4000_0000;
        end else begin
          x_r   <= -y_in;
          y_r   <= x_in;
          ang_r <= 32'hC000_0000;
        end
      end else begin
        x_r   <= x_in;
        y_r   <= y_in;
        ang_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        ang_r <= ang_r + tab;
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        ang_r <= ang_r - tab;
      end
    end
  end

  assign busy  = busy_r;
  assign angle = zero_r ? 16'd0 : rnd[31:16];

endmodule

/* sv/omd_isqrt.sv */
module omd_isqrt
  import omd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);

  logic        busy_r;
  logic [63:0] v_r, r_r, b_r;
  logic [63:0] t;

  assign t = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= val;
      r_r <= '0;
      b_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r <= v_r - t;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[31:0];

endmodule
